### hw/rtl/cspf_pkg.sv
package cspf_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int STACK_DEPTH_DEF   = 1024;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 48;
    localparam int TIME_W   = 48;
    localparam int CNT_W    = 32;
    localparam int TICK_W   = 64;

    // table word: {enter count, exit count, inclusive ticks}
    localparam int TBL_W = CNT_W + CNT_W + TICK_W;
    // stack word: {address, entry time}
    localparam int STK_W = ADDR_W + TIME_W;

    typedef enum logic [OP_W-1:0] {
        OP_ENTER = 2'd0,
        OP_EXIT  = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_MISMATCH = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MAP,
        S_FETCH,
        S_UPDATE
    } state_t;

endpackage

### hw/rtl/cspf_in_if.sv
interface cspf_in_if import cspf_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] func_address;
    logic [TIME_W-1:0] event_time;

    modport source (
        output valid,
        output operation,
        output func_address,
        output event_time,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  func_address,
        input  event_time,
        output ready
    );

endinterface

### hw/rtl/cspf_out_if.sv
interface cspf_out_if import cspf_pkg::*; #(
    parameter int IDX_W = $clog2(TABLE_ENTRIES_DEF),
    parameter int LVL_W = $clog2(STACK_DEPTH_DEF + 1)
) ();

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    table_index;
    logic [CNT_W-1:0]    entry_count;
    logic [CNT_W-1:0]    exit_count;
    logic [TICK_W-1:0]   inclusive_ticks;
    logic [LVL_W-1:0]    stack_level;
    logic [ADDR_W-1:0]   lowest_address;
    logic [ADDR_W-1:0]   highest_address;

    modport source (
        output valid,
        output status,
        output table_index,
        output entry_count,
        output exit_count,
        output inclusive_ticks,
        output stack_level,
        output lowest_address,
        output highest_address,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  table_index,
        input  entry_count,
        input  exit_count,
        input  inclusive_ticks,
        input  stack_level,
        input  lowest_address,
        input  highest_address,
        output ready
    );

endinterface

### hw/rtl/cspf_ram.sv
module cspf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### hw/rtl/call_stack_function_profiler.sv
// Call-stack profiler: each word on req is a function enter, exit or table read
// carrying an address and a tick count; each gives exactly one word on rsp with
// the status, the table entry the address maps to (enter count, exit count,
// inclusive ticks), the stack level and the address range seen. Every word runs
// through a read-modify-write sequence on the profile table memory (map index
// and issue reads, take read data, update and write back) after the cycle in
// which it is taken, and no new word is taken before that sequence is through;
// a stalled rsp holds the sequence in its last step. After reset the table
// memory is cleared one entry per cycle, with req.ready low.
module call_stack_function_profiler import cspf_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int STACK_DEPTH   = STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    cspf_in_if.sink     req,
    cspf_out_if.source  rsp
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int SP_W   = $clog2(STACK_DEPTH);
    localparam int LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int DIFF_W = ADDR_W + 2;

    localparam logic [DIFF_W-1:0] HALF_V   = DIFF_W'(TABLE_ENTRIES / 2);
    localparam logic [DIFF_W-1:0] TBL_V    = DIFF_W'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [LVL_W-1:0]  FULL_LVL = LVL_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    clr_reg;

    logic [OP_W-1:0]     op_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [TIME_W-1:0]   time_reg;
    logic [IDX_W-1:0]    idx_reg, idx_next;

    logic [LVL_W-1:0]    level_reg, level_next;
    logic                base_set_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [ADDR_W-1:0]   low_reg;
    logic [ADDR_W-1:0]   high_reg;

    logic [ADDR_W-1:0]   nl_reg, nl_next;
    logic [ADDR_W-1:0]   nh_reg, nh_next;
    logic                mismatch_reg, mismatch_next;
    logic [TIME_W-1:0]   dt_reg, dt_next;

    logic                out_valid_reg;
    status_t             status_reg, status_next;
    logic [IDX_W-1:0]    out_idx_reg;
    logic [CNT_W-1:0]    out_ent_reg;
    logic [CNT_W-1:0]    out_exc_reg;
    logic [TICK_W-1:0]   out_tick_reg;
    logic [LVL_W-1:0]    out_level_reg;
    logic [ADDR_W-1:0]   out_low_reg;
    logic [ADDR_W-1:0]   out_high_reg;

    logic                accept;
    logic                fire;
    logic                is_upd;
    logic                first;
    logic                commit;
    logic [ADDR_W-1:0]   nb;
    logic [DIFF_W-1:0]   diff;
    logic [LVL_W-1:0]    lvl_dec;

    logic                tbl_wr_en;
    logic [IDX_W-1:0]    tbl_wr_addr;
    logic [TBL_W-1:0]    tbl_wr_data;
    logic                tbl_rd_en;
    logic [TBL_W-1:0]    tbl_rd_data;
    logic                stk_wr_en;
    logic [STK_W-1:0]    stk_rd_data;

    logic [CNT_W-1:0]    ent_old, exc_old, ent_new, exc_new, ent_inc, exc_inc;
    logic [TICK_W-1:0]   tick_old, tick_new, tick_sat;
    logic [TICK_W:0]     tick_sum;
    logic [ADDR_W-1:0]   stk_addr;
    logic [TIME_W-1:0]   stk_time;

    // ---------------- sequencer ----------------
    assign accept = req.valid && req.ready;
    assign fire   = (state_reg == S_UPDATE) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        tbl_rd_en  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                tbl_rd_en  = 1'b1;
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
        end
    end

    // ---------------- index mapping ----------------
    assign is_upd = (op_reg == OP_ENTER) || (op_reg == OP_EXIT);
    assign first  = is_upd && !base_set_reg;
    // base_reg stays zero until set, which is what a read before any base wants
    assign nb     = first ? addr_reg : base_reg;
    assign diff   = {2'b00, addr_reg} - {2'b00, nb} + HALF_V;

    always_comb
    begin
        if (!diff[DIFF_W-1] && (diff < TBL_V))
        begin
            idx_next = diff[IDX_W-1:0];
        end
        else
        begin
            idx_next = '0;
        end
    end

    assign lvl_dec = level_reg - LVL_W'(1);

    // ---------------- stack top check ----------------
    assign stk_addr = stk_rd_data[STK_W-1:TIME_W];
    assign stk_time = stk_rd_data[TIME_W-1:0];

    always_comb
    begin
        mismatch_next = (stk_addr != addr_reg);
        dt_next       = time_reg - stk_time;
        if (!base_set_reg)
        begin
            nl_next = addr_reg;
            nh_next = addr_reg;
        end
        else
        begin
            nl_next = (addr_reg < low_reg)  ? addr_reg : low_reg;
            nh_next = (addr_reg > high_reg) ? addr_reg : high_reg;
        end
    end

    // ---------------- update ----------------
    assign ent_old  = tbl_rd_data[TBL_W-1 -: CNT_W];
    assign exc_old  = tbl_rd_data[TICK_W +: CNT_W];
    assign tick_old = tbl_rd_data[TICK_W-1:0];

    assign ent_inc  = (ent_old == CNT_MAX) ? ent_old : ent_old + CNT_W'(1);
    assign exc_inc  = (exc_old == CNT_MAX) ? exc_old : exc_old + CNT_W'(1);
    assign tick_sum = {1'b0, tick_old} + {{(TICK_W - TIME_W + 1){1'b0}}, dt_reg};
    assign tick_sat = tick_sum[TICK_W] ? {TICK_W{1'b1}} : tick_sum[TICK_W-1:0];

    always_comb
    begin
        status_next = ST_OK;
        ent_new     = ent_old;
        exc_new     = exc_old;
        tick_new    = tick_old;
        level_next  = level_reg;
        case (op_t'(op_reg))
            OP_ENTER:
            begin
                if (level_reg >= FULL_LVL)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    ent_new    = ent_inc;
                    level_next = level_reg + LVL_W'(1);
                end
            end
            OP_EXIT:
            begin
                if (level_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else if (mismatch_reg)
                begin
                    status_next = ST_MISMATCH;
                end
                else
                begin
                    exc_new    = exc_inc;
                    tick_new   = tick_sat;
                    level_next = lvl_dec;
                end
            end
            OP_READ:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign commit    = fire && is_upd && (status_next == ST_OK);
    assign stk_wr_en = commit && (op_reg == OP_ENTER);

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = clr_reg;
            tbl_wr_data = '0;
        end
        else
        begin
            tbl_wr_en   = commit;
            tbl_wr_addr = idx_reg;
            tbl_wr_data = {ent_new, exc_new, tick_new};
        end
    end

    // ---------------- memories ----------------
    cspf_ram #(
        .WIDTH (TBL_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (idx_next),
        .rd_data (tbl_rd_data)
    );

    cspf_ram #(
        .WIDTH (STK_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk     (clk),
        .wr_en   (stk_wr_en),
        .wr_addr (level_reg[SP_W-1:0]),
        .wr_data ({addr_reg, time_reg}),
        .rd_en   (tbl_rd_en),
        .rd_addr (lvl_dec[SP_W-1:0]),
        .rd_data (stk_rd_data)
    );

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= req.operation;
            addr_reg <= req.func_address;
            time_reg <= req.event_time;
        end
        if (state_reg == S_MAP)
        begin
            idx_reg <= idx_next;
        end
        if (state_reg == S_FETCH)
        begin
            mismatch_reg <= mismatch_next;
            dt_reg       <= dt_next;
            nl_reg       <= nl_next;
            nh_reg       <= nh_next;
        end
        if (fire)
        begin
            status_reg    <= status_next;
            out_idx_reg   <= idx_reg;
            out_ent_reg   <= ent_new;
            out_exc_reg   <= exc_new;
            out_tick_reg  <= tick_new;
            out_level_reg <= level_next;
            out_low_reg   <= commit ? nl_reg : low_reg;
            out_high_reg  <= commit ? nh_reg : high_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            base_set_reg  <= 1'b0;
            base_reg      <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                level_reg <= level_next;
            end
            if (commit)
            begin
                base_set_reg <= 1'b1;
                base_reg     <= nb;
                low_reg      <= nl_reg;
                high_reg     <= nh_reg;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.table_index     = out_idx_reg;
    assign rsp.entry_count     = out_ent_reg;
    assign rsp.exit_count      = out_exc_reg;
    assign rsp.inclusive_ticks = out_tick_reg;
    assign rsp.stack_level     = out_level_reg;
    assign rsp.lowest_address  = out_low_reg;
    assign rsp.highest_address = out_high_reg;

endmodule
